FILE: sv/barometric_pressure_compensation_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric pressure compensation block
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpc: same-cycle check failed");
`define BPC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpc: next-cycle check failed");
`else
`define BPC_ASSERT_IMP(lbl, ante, cons)
`define BPC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helpers of the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int DataW    = 32;
	localparam int CfgAddrW = 5;
	localparam int CfgDataW = 64;

	typedef enum logic [1:0] {
		REG_AC123 = 2'd0,
		REG_AC456 = 2'd1,
		REG_B1B2  = 2'd2,
		REG_MCMD  = 2'd3
	} reg_idx_t;

	localparam logic [31:0] T_ROUND   = 32'd8;
	localparam logic [31:0] B6_OFFSET = 32'd4000;
	localparam logic [31:0] B3_ROUND  = 32'd2;
	localparam logic [31:0] B4_BIAS   = 32'd32768;
	localparam logic [31:0] B7_SCALE  = 32'd50000;
	localparam logic [31:0] P_C1      = 32'd3038;
	localparam logic [31:0] P_C2      = 32'hFFFF_E343;
	localparam logic [31:0] P_C3      = 32'd3791;
	localparam logic [31:0] T_MIN     = 32'hFFFF_8000;
	localparam logic [31:0] T_MAX     = 32'h0000_7FFF;
	localparam logic [31:0] P_MAX     = 32'd262143;

	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] mc;
		logic [15:0] md;
	} coef_t;

	typedef struct packed {
		logic [31:0] x1;
		logic [15:0] up;
		logic        neg;
		logic        fault;
	} div1_side_t;

	typedef struct packed {
		logic [15:0] temp;
		logic        post_dbl;
		logic        fault;
	} div2_side_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] a, input int unsigned s);
		return 32'($signed(a) >>> s);
	endfunction

endpackage

FILE: sv/bpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; #(
	parameter int W  = DataW,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [W-1:0]  quo,
	output logic [SW-1:0] side_out
);

	logic [W-1:0]  rem_s  [W];
	logic [W-1:0]  nsh_s  [W];
	logic [W-1:0]  den_s  [W];
	logic [SW-1:0] side_s [W];
	logic          vld_s  [W];

	logic [W-1:0] cur_rem [W];
	logic [W-1:0] cur_nsh [W];
	logic [W-1:0] cur_den [W];
	logic [W:0]   trial   [W];
	logic [W-1:0] nx_rem  [W];
	logic [W-1:0] nx_nsh  [W];

	always_comb begin
		cur_rem[0] = '0;
		cur_nsh[0] = num;
		cur_den[0] = den;
		for (int k = 1; k < W; k++) begin
			cur_rem[k] = rem_s[k-1];
			cur_nsh[k] = nsh_s[k-1];
			cur_den[k] = den_s[k-1];
		end
		for (int k = 0; k < W; k++) begin
			trial[k] = {cur_rem[k], cur_nsh[k][W-1]};
			if (trial[k] >= {1'b0, cur_den[k]}) begin
				nx_rem[k] = W'(trial[k] - {1'b0, cur_den[k]});
				nx_nsh[k] = {cur_nsh[k][W-2:0], 1'b1};
			end else begin
				nx_rem[k] = trial[k][W-1:0];
				nx_nsh[k] = {cur_nsh[k][W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < W; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < W; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < W; k++) side_s[k] <= side_s[k-1];
			for (int k = 0; k < W; k++) begin
				rem_s[k] <= nx_rem[k];
				nsh_s[k] <= nx_nsh[k];
				den_s[k] <= cur_den[k];
			end
		end
	end

	assign out_valid = vld_s[W-1];
	assign quo       = nsh_s[W-1];
	assign side_out  = side_s[W-1];

endmodule

FILE: sv/bpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_front
// Temperature front end: forms x1, the divide operand magnitudes and the quotient sign.
// ----------------------------------------------------------------------------
module bpc_front import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [15:0] raw_t,
	input  logic [15:0] raw_p,
	input  coef_t       coef,
	output logic        out_valid,
	output logic [31:0] num,
	output logic [31:0] den,
	output div1_side_t  side
);

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [31:0] d_s1, m_s2, x1_s3, dv_s3, num_s3;
	logic [15:0] up_s1, up_s2, up_s3;
	logic [31:0] x1_c, dv_c, num_c;
	logic [31:0] num_s4, den_s4;
	div1_side_t  side_s4;

	always_comb begin
		x1_c  = asr(m_s2, 15);
		dv_c  = x1_c + sx16(coef.md);
		num_c = sx16(coef.mc) << 11;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1          <= {16'd0, raw_t} - {16'd0, coef.ac6};
			up_s1         <= raw_p;
			m_s2          <= d_s1 * {16'd0, coef.ac5};
			up_s2         <= up_s1;
			x1_s3         <= x1_c;
			dv_s3         <= dv_c;
			num_s3        <= num_c;
			up_s3         <= up_s2;
			num_s4        <= num_s3[31] ? 32'd0 - num_s3 : num_s3;
			den_s4        <= dv_s3[31] ? 32'd0 - dv_s3 : dv_s3;
			side_s4.x1    <= x1_s3;
			side_s4.up    <= up_s3;
			side_s4.neg   <= num_s3[31] ^ dv_s3[31];
			side_s4.fault <= (dv_s3 == 32'd0);
		end
	end

	assign out_valid = vld_s4;
	assign num       = num_s4;
	assign den       = den_s4;
	assign side      = side_s4;

endmodule

FILE: sv/bpc_mid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_mid
// Finishes temperature, then forms b3, b4 and the pressure divide operands.
// ----------------------------------------------------------------------------
module bpc_mid import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] quo,
	input  div1_side_t  side_in,
	input  coef_t       coef,
	output logic        out_valid,
	output logic [31:0] num,
	output logic [31:0] den,
	output div2_side_t  side
);

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [15:0] temp_s1, temp_s2, temp_s3, temp_s4, temp_s5, temp_s6;
	logic [15:0] up_s1, up_s2, up_s3, up_s4;
	logic        flt_s1, flt_s2, flt_s3, flt_s4, flt_s5, flt_s6;
	logic [31:0] b6_s1, sq_s2, pa2_s2, pa3_s2;
	logic [31:0] px1a_s3, px1b_s3, x2a_s3, x1c_s3;
	logic [31:0] b3_s4, x3p_s4;
	logic [31:0] pb4_s5, dd_s5;
	logic [31:0] b7_s6, b4_s6;
	logic [31:0] num_s7, den_s7;
	div2_side_t  side_s7;

	logic [31:0] b5_c, t_c, b6sq_c, x3_c, v_c;
	logic [15:0] tsat_c;

	always_comb begin
		b5_c = side_in.x1 + (side_in.neg ? 32'd0 - quo : quo);
		t_c  = asr(b5_c + T_ROUND, 4);
		if (t_c[31]) begin
			tsat_c = (t_c < T_MIN) ? T_MIN[15:0] : t_c[15:0];
		end else begin
			tsat_c = (t_c > T_MAX) ? T_MAX[15:0] : t_c[15:0];
		end
		b6sq_c = asr(sq_s2, 12);
		x3_c   = asr(px1a_s3, 11) + x2a_s3;
		v_c    = (sx16(coef.ac1) << 2) + x3_c + B3_ROUND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b6_s1   <= b5_c - B6_OFFSET;
			temp_s1 <= tsat_c;
			up_s1   <= side_in.up;
			flt_s1  <= side_in.fault;

			sq_s2   <= b6_s1 * b6_s1;
			pa2_s2  <= sx16(coef.ac2) * b6_s1;
			pa3_s2  <= sx16(coef.ac3) * b6_s1;
			temp_s2 <= temp_s1;
			up_s2   <= up_s1;
			flt_s2  <= flt_s1;

			px1a_s3 <= sx16(coef.b2) * b6sq_c;
			px1b_s3 <= sx16(coef.b1) * b6sq_c;
			x2a_s3  <= asr(pa2_s2, 11);
			x1c_s3  <= asr(pa3_s2, 13);
			temp_s3 <= temp_s2;
			up_s3   <= up_s2;
			flt_s3  <= flt_s2;

			b3_s4   <= asr(v_c + (v_c[31] ? 32'd3 : 32'd0), 2);
			x3p_s4  <= asr(x1c_s3 + asr(px1b_s3, 16) + B3_ROUND, 2);
			temp_s4 <= temp_s3;
			up_s4   <= up_s3;
			flt_s4  <= flt_s3;

			pb4_s5  <= {16'd0, coef.ac4} * (x3p_s4 + B4_BIAS);
			dd_s5   <= {16'd0, up_s4} - b3_s4;
			temp_s5 <= temp_s4;
			flt_s5  <= flt_s4;

			b7_s6   <= dd_s5 * B7_SCALE;
			b4_s6   <= pb4_s5 >> 15;
			temp_s6 <= temp_s5;
			flt_s6  <= flt_s5;

			num_s7           <= b7_s6[31] ? b7_s6 : b7_s6 << 1;
			den_s7           <= b4_s6;
			side_s7.temp     <= temp_s6;
			side_s7.post_dbl <= b7_s6[31];
			side_s7.fault    <= flt_s6 | (b4_s6 == 32'd0);
		end
	end

	assign out_valid = vld_s7;
	assign num       = num_s7;
	assign den       = den_s7;
	assign side      = side_s7;

endmodule

FILE: sv/bpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_back
// Pressure correction polynomial, clamping and fault zeroing of the result.
// ----------------------------------------------------------------------------
module bpc_back import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] quo,
	input  div2_side_t  side_in,
	output logic        out_valid,
	output logic [15:0] temp,
	output logic [17:0] pres,
	output logic        fault
);

	logic        vld_s1, vld_s2, vld_s3;
	logic [31:0] p_c, a_c;
	logic [31:0] p_s1, sq_s1, pn_s1, p_s2, px_s2, x2_s2;
	logic [15:0] temp_s1, temp_s2, temp_s3;
	logic        flt_s1, flt_s2, flt_s3;
	logic [17:0] pres_s3;
	logic [31:0] pr_c;
	logic [17:0] pclamp_c;

	always_comb begin
		p_c  = side_in.post_dbl ? quo << 1 : quo;
		a_c  = asr(p_c, 8);
		pr_c = p_s2 + asr(asr(px_s2, 16) + x2_s2 + P_C3, 4);
		if (pr_c[31]) begin
			pclamp_c = '0;
		end else if (pr_c > P_MAX) begin
			pclamp_c = P_MAX[17:0];
		end else begin
			pclamp_c = pr_c[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= p_c;
			sq_s1   <= a_c * a_c;
			pn_s1   <= P_C2 * p_c;
			temp_s1 <= side_in.temp;
			flt_s1  <= side_in.fault;

			p_s2    <= p_s1;
			px_s2   <= sq_s1 * P_C1;
			x2_s2   <= asr(pn_s1, 16);
			temp_s2 <= temp_s1;
			flt_s2  <= flt_s1;

			temp_s3 <= flt_s2 ? 16'd0 : temp_s2;
			pres_s3 <= flt_s2 ? 18'd0 : pclamp_c;
			flt_s3  <= flt_s2;
		end
	end

	assign out_valid = vld_s3;
	assign temp      = temp_s3;
	assign pres      = pres_s3;
	assign fault     = flt_s3;

endmodule

FILE: sv/barometric_pressure_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// Compensates raw temperature and pressure words with stored calibration.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_axis   | in        | tdata[15:0] raw temperature, tdata[31:16] raw pressure
// m_axis   | out       | tdata temperature and pressure, tuser divide fault
// apb      | cfg       | four calibration registers at byte addresses 0, 8, 16, 24
//
// One beat is accepted per cycle while the output is not stalled; a result passes through
// the two 32-stage divide pipelines and 14 further arithmetic stages.
// The whole pipeline advances together and freezes while the output beat waits.
// Reset clears all valid bits and the calibration registers; no clearing pass.
// ----------------------------------------------------------------------------
`include "barometric_pressure_compensation_top_macros.svh"

module barometric_pressure_compensation_top import bpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,   // raw_temperature[15:0], raw_pressure[31:16]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,   // temperature_tenths[15:0], pressure_pa[33:16], zero
	output logic [0:0]          m_tuser,   // divide_fault[0]
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready
);

	logic [47:0] coef_ac123_q, coef_ac456_q;
	logic [31:0] coef_b1b2_q, coef_mcmd_q;
	coef_t       coef;
	reg_idx_t    widx;
	logic        wr_en, en;

	logic        f_vld, d1_vld, mid_vld, d2_vld, b_vld;
	logic [31:0] f_num, f_den, d1_quo, mid_num, mid_den, d2_quo;
	div1_side_t  f_side, d1_side;
	div2_side_t  mid_side, d2_side;
	logic [15:0] b_temp;
	logic [17:0] b_pres;
	logic        b_fault;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign widx   = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_ac123_q <= '0;
			coef_ac456_q <= '0;
			coef_b1b2_q  <= '0;
			coef_mcmd_q  <= '0;
		end else if (wr_en) begin
			case (widx)
				REG_AC123: coef_ac123_q <= pwdata[47:0];
				REG_AC456: coef_ac456_q <= pwdata[47:0];
				REG_B1B2:  coef_b1b2_q  <= pwdata[31:0];
				REG_MCMD:  coef_mcmd_q  <= pwdata[31:0];
				default:   coef_mcmd_q  <= coef_mcmd_q;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_AC123: prdata = {16'd0, coef_ac123_q};
			REG_AC456: prdata = {16'd0, coef_ac456_q};
			REG_B1B2:  prdata = {32'd0, coef_b1b2_q};
			REG_MCMD:  prdata = {32'd0, coef_mcmd_q};
			default:   prdata = '0;
		endcase
	end

	assign coef = {coef_ac123_q, coef_ac456_q, coef_b1b2_q, coef_mcmd_q};

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	bpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.raw_t     (s_tdata[15:0]),
		.raw_p     (s_tdata[31:16]),
		.coef      (coef),
		.out_valid (f_vld),
		.num       (f_num),
		.den       (f_den),
		.side      (f_side)
	);

	bpc_div #(.W(DataW), .SW($bits(div1_side_t))) u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_vld),
		.num       (f_num),
		.den       (f_den),
		.side_in   (f_side),
		.out_valid (d1_vld),
		.quo       (d1_quo),
		.side_out  (d1_side)
	);

	bpc_mid u_mid (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d1_vld),
		.quo       (d1_quo),
		.side_in   (d1_side),
		.coef      (coef),
		.out_valid (mid_vld),
		.num       (mid_num),
		.den       (mid_den),
		.side      (mid_side)
	);

	bpc_div #(.W(DataW), .SW($bits(div2_side_t))) u_div_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mid_vld),
		.num       (mid_num),
		.den       (mid_den),
		.side_in   (mid_side),
		.out_valid (d2_vld),
		.quo       (d2_quo),
		.side_out  (d2_side)
	);

	bpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d2_vld),
		.quo       (d2_quo),
		.side_in   (d2_side),
		.out_valid (b_vld),
		.temp      (b_temp),
		.pres      (b_pres),
		.fault     (b_fault)
	);

	assign m_tvalid = b_vld;
	assign m_tdata  = {6'd0, b_pres, b_temp};
	assign m_tuser  = b_fault;

	// A faulted beat carries zero results.
	`BPC_ASSERT_IMP(a_fault_zero, m_tvalid && m_tuser[0], m_tdata[33:0] == 34'd0)
	// A zero pressure divisor must already be flagged before the divider.
	`BPC_ASSERT_IMP(a_b4_fault, mid_vld && (mid_den == 32'd0), mid_side.fault)
	// A write to the last register lands on the next edge.
	`BPC_ASSERT_NXT(a_cfg_write, wr_en && (widx == REG_MCMD), coef_mcmd_q == $past(pwdata[31:0]))

endmodule

FILE: tb/barometric_pressure_compensation_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top_test
// Streams raw temperature and pressure words through the compensation block
// under several calibration sets and compares every output beat with a
// behavioural calculation held in the testbench.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_top_test;
	import bpc_pkg::*;

	typedef struct packed {
		logic [15:0] temp;
		logic [17:0] pres;
		logic        fault;
	} comp_t;

	typedef struct {
		logic [15:0] ut;
		logic [15:0] up;
		bit          known;
		comp_t       res;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [31:0]         s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [39:0]         m_tdata;   // temperature_tenths[15:0], pressure_pa[33:16], zero
	logic [0:0]          m_tuser;   // divide_fault[0]
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [CfgAddrW-1:0] paddr = '0;
	logic [CfgDataW-1:0] pwdata = '0;
	logic [CfgDataW-1:0] prdata;
	logic                pready;

	logic [47:0] cal_ac123, cal_ac456;
	logic [31:0] cal_b12, cal_mcmd;
	comp_t       pending_q[$];
	int          err_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_off = 0;
	int          quiet_cycles = 0;

	barometric_pressure_compensation_top u_top (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] sra(logic [31:0] a, int s);
		return 32'($signed(a) >>> s);
	endfunction

	function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic comp_t compensate(logic [15:0] raw_t, logic [15:0] raw_p);
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
		logic [31:0] x1, x2, x3, dv, b5, b6, b6sq, b3, b4, b7, p, t, pr;
		comp_t r;
		ac1 = {{16{cal_ac123[47]}}, cal_ac123[47:32]};
		ac2 = {{16{cal_ac123[31]}}, cal_ac123[31:16]};
		ac3 = {{16{cal_ac123[15]}}, cal_ac123[15:0]};
		ac4 = {16'h0, cal_ac456[47:32]};
		ac5 = {16'h0, cal_ac456[31:16]};
		ac6 = {16'h0, cal_ac456[15:0]};
		b1 = {{16{cal_b12[31]}}, cal_b12[31:16]};
		b2 = {{16{cal_b12[15]}}, cal_b12[15:0]};
		mc = {{16{cal_mcmd[31]}}, cal_mcmd[31:16]};
		md = {{16{cal_mcmd[15]}}, cal_mcmd[15:0]};
		ut = {16'h0, raw_t};
		up = {16'h0, raw_p};
		r = '0;
		x1 = sra((ut - ac6) * ac5, 15);
		dv = x1 + md;
		if (dv == 0) begin
			r.fault = 1'b1;
			return r;
		end
		x2 = sdiv(mc * 32'd2048, dv);
		b5 = x1 + x2;
		t = sra(b5 + 32'd8, 4);
		b6 = b5 - 32'd4000;
		b6sq = sra(b6 * b6, 12);
		x1 = sra(b2 * b6sq, 11);
		x2 = sra(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = sdiv(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
		x1 = sra(ac3 * b6, 13);
		x2 = sra(b1 * b6sq, 16);
		x3 = sra(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		if (b4 == 0) begin
			r.fault = 1'b1;
			return r;
		end
		b7 = (up - b3) * 32'd50000;
		if (!b7[31])
			p = (b7 * 32'd2) / b4;
		else
			p = (b7 / b4) * 32'd2;
		x1 = sra(p, 8) * sra(p, 8);
		x1 = sra(x1 * 32'd3038, 16);
		x2 = sra(-32'd7357 * p, 16);
		pr = p + sra(x1 + x2 + 32'd3791, 4);
		if (t[31]) begin
			if (t < 32'hFFFF_8000)
				t = 32'hFFFF_8000;
		end else if (t > 32'h7FFF) begin
			t = 32'h7FFF;
		end
		if (pr[31])
			pr = 0;
		else if (pr > 32'd262143)
			pr = 32'd262143;
		r.temp = t[15:0];
		r.pres = pr[17:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	task automatic write_coef(reg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CfgAddrW'(8 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_AC123: cal_ac123 = val[47:0];
			REG_AC456: cal_ac456 = val[47:0];
			REG_B1B2:  cal_b12 = val[31:0];
			REG_MCMD:  cal_mcmd = val[31:0];
			default:   ;
		endcase
	endtask

	task automatic load_cal(logic [47:0] a, logic [47:0] b, logic [31:0] c, logic [31:0] d);
		write_coef(REG_AC123, {16'h0, a});
		write_coef(REG_AC456, {16'h0, b});
		write_coef(REG_B1B2, {32'h0, c});
		write_coef(REG_MCMD, {32'h0, d});
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (90) @(posedge clk);
	endtask

	task automatic send_beat(logic [15:0] ut, logic [15:0] up, bit known, comp_t want);
		comp_t calc;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {up, ut};
		calc = compensate(ut, up);
		if (known && calc != want)
			report_mismatch("directed row", 64'(calc), 64'(want));
		pending_q.push_back(calc);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		comp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected beat", 64'(m_tdata), 64'(0));
			end else begin
				want = pending_q.pop_front();
				if (m_tdata[15:0] !== want.temp)
					report_mismatch("temperature_tenths", 64'(m_tdata[15:0]), 64'(want.temp));
				if (m_tdata[33:16] !== want.pres)
					report_mismatch("pressure_pa", 64'(m_tdata[33:16]), 64'(want.pres));
				if (m_tuser[0] !== want.fault)
					report_mismatch("divide_fault", 64'(m_tuser[0]), 64'(want.fault));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("barometric_pressure_compensation_top_test: done, errors");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		comp_t zero_fault;
		logic [47:0] cal_a, cal_b;
		logic [31:0] cal_c, cal_d;
		int phase;
		zero_fault = '0;
		zero_fault.fault = 1'b1;
		cal_ac123 = '0;
		cal_ac456 = '0;
		cal_b12 = '0;
		cal_mcmd = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every coefficient is zero, so the temperature divisor is zero.
		rows.push_back('{16'h0000, 16'h0000, 1, zero_fault});
		rows.push_back('{16'hFFFF, 16'hFFFF, 1, zero_fault});
		foreach (rows[i])
			send_beat(rows[i].ut, rows[i].up, rows[i].known, rows[i].res);
		drain();

		// Typical datasheet calibration.
		load_cal({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
			{16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
		rows.delete();
		rows.push_back('{16'd27898, 16'd23843, 0, '0});
		rows.push_back('{16'h0000, 16'h0000, 0, '0});
		rows.push_back('{16'hFFFF, 16'hFFFF, 0, '0});
		rows.push_back('{16'h0000, 16'hFFFF, 0, '0});
		rows.push_back('{16'hFFFF, 16'h0000, 0, '0});
		rows.push_back('{16'h8000, 16'h5555, 0, '0});
		rows.push_back('{16'h7FFF, 16'hAAAA, 0, '0});
		foreach (rows[i])
			send_beat(rows[i].ut, rows[i].up, rows[i].known, rows[i].res);
		drain();

		// Zero ac4 makes the pressure divisor zero.
		write_coef(REG_AC456, {16'h0, 16'h0, 16'd32757, 16'd23153});
		send_beat(16'd27898, 16'd23843, 1, zero_fault);
		send_beat(16'h1234, 16'h0000, 1, zero_fault);
		drain();

		// Extreme coefficients: saturation, clamping and divide overflow.
		load_cal({16'h8000, 16'h7FFF, 16'h8000}, {16'hFFFF, 16'hFFFF, 16'h0000},
			{16'h8000, 16'h7FFF}, {16'h8000, 16'h0001});
		for (int i = 0; i < 6; i++)
			send_beat(16'($urandom), 16'($urandom), 0, '0);
		send_beat(16'hFFFF, 16'hFFFF, 0, '0);
		send_beat(16'h0000, 16'h0000, 0, '0);
		drain();
		load_cal({16'h7FFF, 16'h8000, 16'h7FFF}, {16'h0001, 16'hFFFF, 16'hFFFF},
			{16'h7FFF, 16'h8000}, {16'h7FFF, 16'hFFFF});
		send_beat(16'hFFFF, 16'h0000, 0, '0);
		send_beat(16'h0000, 16'hFFFF, 0, '0);
		drain();

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 62 : 0;
			recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 9 : 0;
			if (phase == 2)
				cal_a = $urandom_range(1) ? 48'hFFFF_FFFF_FFFF : 48'h0;
			cal_a = {16'($urandom), 16'($urandom), 16'($urandom)};
			cal_b = {16'($urandom), 16'($urandom), 16'($urandom)};
			cal_c = $urandom;
			cal_d = $urandom;
			if (phase == 0) begin
				cal_a = {16'd408, -16'sd72, -16'sd14383};
				cal_b = {16'd32741, 16'd32757, 16'd23153};
				cal_c = {16'd6190, 16'd4};
				cal_d = {-16'sd8711, 16'd2868};
			end
			load_cal(cal_a, cal_b, cal_c, cal_d);
			for (int i = 0; i < 300; i++) begin
				if (phase == 2 && i == 50)
					hold_off = 400;
				if (phase == 1 && i == 150) begin
					s_tvalid <= 1'b0;
					while (pending_q.size() != 0)
						@(posedge clk);
					write_coef(REG_B1B2, {32'h0, 32'($urandom)});
				end
				if (phase == 0 && $urandom_range(3) != 0)
					send_beat(16'($urandom_range(22000, 34000)),
						16'($urandom_range(20000, 30000)), 0, '0);
				else
					send_beat(16'($urandom), 16'($urandom), 0, '0);
			end
			drain();
		end

		if (err_count == 0)
			$display("barometric_pressure_compensation_top_test: done, clean");
		else
			$display("barometric_pressure_compensation_top_test: done, errors");
		$finish;
	end

endmodule

FILE: barometric_pressure_compensation_top.f
+incdir+sv
sv/bpc_pkg.sv
sv/bpc_div.sv
sv/bpc_front.sv
sv/bpc_mid.sv
sv/bpc_back.sv
sv/barometric_pressure_compensation_top.sv
tb/barometric_pressure_compensation_top_test.sv
